[hdl/xmt_pkg.sv]
`timescale 1ns / 1ps
package xmt_pkg;
    localparam int ENTITY_MAX_LEN = 5;
    localparam int ELW = $clog2(ENTITY_MAX_LEN + 1);

    typedef enum logic [4:0] {
        M_START, M_AFTER_GT, M_AFTER_LT, M_PRE_CLOSE, M_PRE_PROLOG,
        M_NAME_TAG, M_NAME_CLOSE, M_NAME_PROLOG, M_BANG, M_DASH1,
        M_COMMENT, M_ATTR_SKIP, M_ATTR_NAME, M_POST_NAME, M_VAL_PRE,
        M_VAL_BODY, M_TEXT, M_ENTITY, M_SLASH, M_QM, M_ERR
    } t_mode;

    localparam logic [1:0] OK_DATA = 2'd0;
    localparam logic [1:0] OK_DONE = 2'd1;
    localparam logic [1:0] OK_ERR  = 2'd2;

    localparam logic [3:0] TK_TAG = 4'd0, TK_CLOSE = 4'd1, TK_SELF = 4'd2,
        TK_PRO_BEG = 4'd3, TK_PRO_END = 4'd4, TK_ATTR = 4'd5, TK_VAL = 4'd6,
        TK_TEXT = 4'd7, TK_END = 4'd8;

    localparam logic [3:0] E_SLASH = 4'd0, E_QM = 4'd1, E_AFTER_LT = 4'd2,
        E_TEXT_END = 4'd3, E_TAG_CHAR = 4'd4, E_COMMENT = 4'd5,
        E_ATTR_END = 4'd6, E_ATTR_CHAR = 4'd7, E_NO_QUOTE = 4'd8,
        E_WRONG_QUOTE = 4'd9, E_VAL_END = 4'd10, E_ENTITY = 4'd11,
        E_STRAY = 4'd12;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [3:0] token_kind;
        logic [7:0] data_char;
        logic [3:0] error_code;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9");
    endfunction
endpackage

[hdl/xml_markup_tokenizer.sv]
`timescale 1ns / 1ps
// Streaming XML lexer: one byte per transaction, zero ends the document. Each byte
// is decided combinationally by the mode register and the five-byte entity buffer, so
// a new byte is taken every cycle while the skid stage is empty; a result register,
// together with a skid stage, keeps input flowing while one result waits. Each byte
// yields zero or one result; after an error, bytes are dropped until a zero byte.
module xml_markup_tokenizer import xmt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_kind,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_data_char,
    output logic [3:0] o_error_code
);
    t_mode          r_mode, n_mode;
    logic           r_apos, n_apos;
    logic [ELW-1:0] r_elen, n_elen;
    logic           r_einval, n_einval;
    logic [1:0]     r_dash, n_dash;
    logic           r_ov, r_sv;
    t_result        r_out, r_skid, res;
    logic           emit, ent_wr, ent_hit;
    logic [7:0]     ent_ch, c;
    logic           acc;

    assign c       = i_char_code;
    assign o_ready = !r_sv;
    assign acc     = i_valid && o_ready;

    xmt_entity u_ent (
        .i_clk (i_clk), .i_wr(acc && ent_wr), .i_len(n_elen == ELW'(1) ? '0 : r_elen),
        .i_char(c), .o_hit(ent_hit), .o_char(ent_ch)
    );

    always_comb begin
        n_mode = r_mode; n_apos = r_apos; n_elen = r_elen;
        n_einval = r_einval; n_dash = r_dash;
        emit = 1'b0; res = '0; ent_wr = 1'b0;
        unique case (r_mode)
            M_AFTER_GT, M_TEXT: begin
                if (r_mode == M_AFTER_GT && is_ws(c)) begin
                end else if (r_mode == M_AFTER_GT && c == "<") begin
                    n_mode = M_AFTER_LT;
                end else if (r_mode == M_AFTER_GT && c == 8'h00) begin
                    n_mode = M_START; emit = 1'b1; res.out_kind = OK_DONE;
                    res.token_kind = TK_END;
                end else if (c == "<") begin
                    n_mode = M_AFTER_LT; emit = 1'b1; res.out_kind = OK_DONE;
                    res.token_kind = TK_TEXT;
                end else if (c == "&") begin
                    ent_wr = 1'b1; n_elen = ELW'(1); n_einval = 1'b0; n_mode = M_ENTITY;
                end else if (c == 8'h00) begin
                    n_mode = M_START; emit = 1'b1; res.out_kind = OK_ERR;
                    res.error_code = E_TEXT_END;
                end else begin
                    n_mode = M_TEXT; emit = 1'b1; res.token_kind = TK_TEXT;
                    res.data_char = c;
                end
            end
            M_AFTER_LT: begin
                emit = 1'b1;
                if (is_alpha(c)) begin
                    n_mode = M_NAME_TAG; res.token_kind = TK_TAG; res.data_char = c;
                end else if (c == "/") begin
                    n_mode = M_PRE_CLOSE; emit = 1'b0;
                end else if (c == "!") begin
                    n_mode = M_BANG; emit = 1'b0;
                end else if (c == "?") begin
                    n_mode = M_PRE_PROLOG; emit = 1'b0;
                end else begin
                    res.out_kind = OK_ERR; res.error_code = E_AFTER_LT;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end
            end
            M_PRE_CLOSE, M_PRE_PROLOG, M_NAME_TAG, M_NAME_CLOSE, M_NAME_PROLOG: begin
                if ((r_mode == M_PRE_CLOSE || r_mode == M_PRE_PROLOG) && is_ws(c)) begin
                end else begin
                    emit = 1'b1;
                    res.token_kind = (r_mode == M_PRE_CLOSE || r_mode == M_NAME_CLOSE)
                        ? TK_CLOSE
                        : (r_mode == M_NAME_TAG ? TK_TAG : TK_PRO_BEG);
                    if (r_mode == M_PRE_CLOSE) n_mode = M_NAME_CLOSE;
                    if (r_mode == M_PRE_PROLOG) n_mode = M_NAME_PROLOG;
                    if (c == ">") begin
                        n_mode = M_AFTER_GT; res.out_kind = OK_DONE;
                    end else if (is_ws(c)) begin
                        n_mode = M_ATTR_SKIP; res.out_kind = OK_DONE;
                    end else if (is_word(c)) begin
                        res.data_char = c;
                    end else begin
                        res = '0; res.out_kind = OK_ERR; res.error_code = E_TAG_CHAR;
                        n_mode = c == 8'h00 ? M_START : M_ERR;
                    end
                end
            end
            M_BANG, M_DASH1: begin
                if (c == "-") begin
                    n_mode = r_mode == M_BANG ? M_DASH1 : M_COMMENT;
                    if (r_mode == M_DASH1) n_dash = 2'd0;
                end else begin
                    emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_COMMENT;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end
            end
            M_COMMENT: begin
                if (c == 8'h00) begin
                    emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_COMMENT;
                    n_mode = M_START;
                end else if (r_dash >= 2'd2) begin
                    n_dash = 2'd0;
                    if (c == ">") begin
                        n_mode = M_AFTER_GT;
                    end else begin
                        emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_COMMENT;
                        n_mode = M_ERR;
                    end
                end else begin
                    n_dash = c == "-" ? r_dash + 2'd1 : 2'd0;
                end
            end
            M_ATTR_NAME: begin
                emit = 1'b1; res.token_kind = TK_ATTR;
                if (c == "=") begin
                    n_mode = M_VAL_PRE; res.out_kind = OK_DONE;
                end else if (is_ws(c)) begin
                    n_mode = M_POST_NAME; res.out_kind = OK_DONE;
                end else if (is_word(c)) begin
                    res.data_char = c;
                end else begin
                    res.token_kind = TK_TAG; res.out_kind = OK_ERR;
                    res.error_code = c == 8'h00 ? E_ATTR_END : E_ATTR_CHAR;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end
            end
            M_VAL_PRE: begin
                if (is_ws(c)) begin
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_apos = c == 8'h27; n_mode = M_VAL_BODY;
                end else begin
                    emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_NO_QUOTE;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end
            end
            M_VAL_BODY: begin
                emit = 1'b1; res.token_kind = TK_VAL;
                if (c == (r_apos ? 8'h27 : 8'h22)) begin
                    n_mode = M_START; res.out_kind = OK_DONE;
                end else if (c == 8'h22 || c == 8'h27) begin
                    res.token_kind = TK_TAG; res.out_kind = OK_ERR;
                    res.error_code = E_WRONG_QUOTE; n_mode = M_ERR;
                end else if (c == "&") begin
                    emit = 1'b0; ent_wr = 1'b1; n_elen = ELW'(1); n_einval = 1'b1;
                    n_mode = M_ENTITY;
                end else if (c == 8'h00) begin
                    res.token_kind = TK_TAG; res.out_kind = OK_ERR;
                    res.error_code = E_VAL_END; n_mode = M_START;
                end else begin
                    res.data_char = c;
                end
            end
            M_ENTITY: begin
                if (c == ";" && ent_hit) begin
                    emit = 1'b1; res.data_char = ent_ch;
                    res.token_kind = r_einval ? TK_VAL : TK_TEXT;
                    n_mode = r_einval ? M_VAL_BODY : M_TEXT;
                end else if (c == 8'h00 || c == ";" || r_elen >= ELW'(ENTITY_MAX_LEN)) begin
                    emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_ENTITY;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end else begin
                    ent_wr = 1'b1; n_elen = r_elen + ELW'(1);
                end
            end
            M_SLASH, M_QM: begin
                emit = 1'b1;
                if (c == ">") begin
                    n_mode = M_AFTER_GT; res.out_kind = OK_DONE;
                    res.token_kind = r_mode == M_SLASH ? TK_SELF : TK_PRO_END;
                end else begin
                    res.out_kind = OK_ERR;
                    res.error_code = r_mode == M_SLASH ? E_SLASH : E_QM;
                    n_mode = c == 8'h00 ? M_START : M_ERR;
                end
            end
            M_ERR: begin
                if (c == 8'h00) n_mode = M_START;
            end
            default: begin
                // start, attribute skip, after attribute name
                if (is_ws(c) && r_mode != M_START) begin
                end else if (is_alpha(c) && r_mode == M_ATTR_SKIP) begin
                    n_mode = M_ATTR_NAME; emit = 1'b1; res.token_kind = TK_ATTR;
                    res.data_char = c;
                end else if (c == 8'h00) begin
                    n_mode = M_START; emit = 1'b1; res.out_kind = OK_DONE;
                    res.token_kind = TK_END;
                end else if (is_ws(c)) begin
                    n_mode = M_ATTR_SKIP;
                end else if (c == ">") begin
                    n_mode = M_AFTER_GT;
                end else if (c == "<") begin
                    n_mode = M_AFTER_LT;
                end else if (c == "=") begin
                    n_mode = M_VAL_PRE;
                end else if (c == "/") begin
                    n_mode = M_SLASH;
                end else if (c == "?") begin
                    n_mode = M_QM;
                end else begin
                    emit = 1'b1; res.out_kind = OK_ERR; res.error_code = E_STRAY;
                    n_mode = M_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START; r_apos <= 1'b0; r_elen <= '0;
            r_einval <= 1'b0; r_dash <= 2'd0; r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (acc) begin
                r_mode <= n_mode; r_apos <= n_apos; r_elen <= n_elen;
                r_einval <= n_einval; r_dash <= n_dash;
            end
            // output register with skid: park a new result if the output is stalled
            if (!r_ov || i_ready) begin
                r_ov <= r_sv || (acc && emit);
                r_sv <= 1'b0;
            end else if (acc && emit) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            r_out <= r_sv ? r_skid : res;
        end
        if (acc && emit && r_ov && !i_ready) begin
            r_skid <= res;
        end
    end

    assign o_valid      = r_ov;
    assign o_out_kind   = r_out.out_kind;
    assign o_token_kind = r_out.token_kind;
    assign o_data_char  = r_out.data_char;
    assign o_error_code = r_out.error_code;

    a_skid_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid holds data while output empty");
    a_no_input_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !o_ready) else $error("input taken with skid full");
    a_entity_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_ENTITY |-> (r_elen != '0 && r_elen <= ELW'(ENTITY_MAX_LEN)))
        else $error("entity length out of range");
endmodule

[hdl/xmt_entity.sv]
`timescale 1ns / 1ps
module xmt_entity import xmt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_wr,
    input  logic [ELW-1:0] i_len,
    input  logic [7:0]     i_char,
    output logic           o_hit,
    output logic [7:0]     o_char
);
    logic [7:0] r_buf [ENTITY_MAX_LEN];

    // entry 0 always holds '&', so only the bytes after it are compared
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_buf[i_len[ELW-1:0] < ELW'(ENTITY_MAX_LEN) ? i_len : '0] <= i_char;
        end
    end

    always_comb begin
        o_hit  = 1'b0;
        o_char = 8'h00;
        if (i_len == ELW'(3) && r_buf[1] == "l" && r_buf[2] == "t") begin
            o_hit = 1'b1; o_char = "<";
        end else if (i_len == ELW'(3) && r_buf[1] == "g" && r_buf[2] == "t") begin
            o_hit = 1'b1; o_char = ">";
        end else if (i_len == ELW'(4) && r_buf[1] == "a" && r_buf[2] == "m"
                     && r_buf[3] == "p") begin
            o_hit = 1'b1; o_char = "&";
        end else if (i_len == ELW'(5) && r_buf[1] == "a" && r_buf[2] == "p"
                     && r_buf[3] == "o" && r_buf[4] == "s") begin
            o_hit = 1'b1; o_char = 8'h27;
        end else if (i_len == ELW'(5) && r_buf[1] == "q" && r_buf[2] == "u"
                     && r_buf[3] == "o" && r_buf[4] == "t") begin
            o_hit = 1'b1; o_char = 8'h22;
        end
    end
endmodule

[test/xml_markup_tokenizer_tb.sv]
`timescale 1ns / 1ps
module xml_markup_tokenizer_tb;
    import xmt_pkg::*;

    localparam int LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_char_code;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_out_kind;
    logic [3:0] o_token_kind;
    logic [7:0] o_data_char;
    logic [3:0] o_error_code;

    xml_markup_tokenizer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_char_code(i_char_code),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_kind(o_out_kind), .o_token_kind(o_token_kind),
        .o_data_char(o_data_char), .o_error_code(o_error_code)
    );

    // lexer shadow state
    t_mode      lx_mode;
    logic       lx_apos;
    logic [7:0] lx_ent [ENTITY_MAX_LEN];
    int         lx_ent_len;
    logic       lx_ent_val;
    int         lx_dashes;

    t_result token_q[$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    bit      idle_en;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic bit alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
    endfunction

    function automatic bit wordc(input logic [7:0] c);
        return alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    task automatic emit(input logic [1:0] ok, input logic [3:0] tk,
                        input logic [7:0] dc, input logic [3:0] ec);
        t_result r;
        r.out_kind = ok;
        r.token_kind = tk;
        r.data_char = dc;
        r.error_code = ec;
        token_q = {token_q, r};
    endtask

    task automatic lex_fail(input logic [7:0] c, input logic [3:0] code);
        lx_mode = (c == 0) ? M_START : M_ERR;
        emit(OK_ERR, TK_TAG, 8'h00, code);
    endtask

    task automatic lex_dispatch(input logic [7:0] c);
        if (c == 0) begin
            lx_mode = M_START;
            emit(OK_DONE, TK_END, 8'h00, 4'd0);
        end else if (ws(c)) lx_mode = M_ATTR_SKIP;
        else if (c == ">") lx_mode = M_AFTER_GT;
        else if (c == "<") lx_mode = M_AFTER_LT;
        else if (c == "=") lx_mode = M_VAL_PRE;
        else if (c == "/") lx_mode = M_SLASH;
        else if (c == "?") lx_mode = M_QM;
        else lex_fail(c, E_STRAY);
    endtask

    task automatic lex_name(input logic [7:0] c, input logic [3:0] tk);
        if (c == ">") begin
            lx_mode = M_AFTER_GT;
            emit(OK_DONE, tk, 8'h00, 4'd0);
        end else if (ws(c)) begin
            lx_mode = M_ATTR_SKIP;
            emit(OK_DONE, tk, 8'h00, 4'd0);
        end else if (wordc(c)) emit(OK_DATA, tk, c, 4'd0);
        else lex_fail(c, E_TAG_CHAR);
    endtask

    task automatic lex_open_entity(input logic in_val);
        lx_ent[0] = "&";
        lx_ent_len = 1;
        lx_ent_val = in_val;
        lx_mode = M_ENTITY;
    endtask

    task automatic lex_text(input logic [7:0] c);
        if (c == "<") begin
            lx_mode = M_AFTER_LT;
            emit(OK_DONE, TK_TEXT, 8'h00, 4'd0);
        end else if (c == "&") lex_open_entity(1'b0);
        else if (c == 0) lex_fail(c, E_TEXT_END);
        else begin
            lx_mode = M_TEXT;
            emit(OK_DATA, TK_TEXT, c, 4'd0);
        end
    endtask

    function automatic bit ent_is(input string s);
        if (s.len() != lx_ent_len) return 0;
        for (int k = 0; k < s.len(); k++)
            if (lx_ent[k] != s[k]) return 0;
        return 1;
    endfunction

    task automatic lex_entity(input logic [7:0] c);
        logic [7:0] dec;
        bit         hit;
        hit = 1;
        if (c == 0) lex_fail(c, E_ENTITY);
        else if (c == ";") begin
            if (ent_is("&lt")) dec = "<";
            else if (ent_is("&gt")) dec = ">";
            else if (ent_is("&amp")) dec = "&";
            else if (ent_is("&apos")) dec = 8'h27;
            else if (ent_is("&quot")) dec = 8'h22;
            else hit = 0;
            if (hit) begin
                lx_mode = lx_ent_val ? M_VAL_BODY : M_TEXT;
                emit(OK_DATA, lx_ent_val ? TK_VAL : TK_TEXT, dec, 4'd0);
            end else lex_fail(c, E_ENTITY);
        end else if (lx_ent_len >= ENTITY_MAX_LEN) lex_fail(c, E_ENTITY);
        else begin
            lx_ent[lx_ent_len] = c;
            lx_ent_len++;
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        logic [7:0] q;
        case (lx_mode)
            M_AFTER_GT: begin
                if (ws(c)) ;
                else if (c == "<") lx_mode = M_AFTER_LT;
                else if (c == 0) begin
                    lx_mode = M_START;
                    emit(OK_DONE, TK_END, 8'h00, 4'd0);
                end else lex_text(c);
            end
            M_TEXT: lex_text(c);
            M_AFTER_LT: begin
                if (alpha(c)) begin
                    lx_mode = M_NAME_TAG;
                    emit(OK_DATA, TK_TAG, c, 4'd0);
                end else if (c == "/") lx_mode = M_PRE_CLOSE;
                else if (c == "!") lx_mode = M_BANG;
                else if (c == "?") lx_mode = M_PRE_PROLOG;
                else lex_fail(c, E_AFTER_LT);
            end
            M_PRE_CLOSE: if (!ws(c)) begin
                lx_mode = M_NAME_CLOSE;
                lex_name(c, TK_CLOSE);
            end
            M_PRE_PROLOG: if (!ws(c)) begin
                lx_mode = M_NAME_PROLOG;
                lex_name(c, TK_PRO_BEG);
            end
            M_NAME_TAG: lex_name(c, TK_TAG);
            M_NAME_CLOSE: lex_name(c, TK_CLOSE);
            M_NAME_PROLOG: lex_name(c, TK_PRO_BEG);
            M_BANG: begin
                if (c == "-") lx_mode = M_DASH1;
                else lex_fail(c, E_COMMENT);
            end
            M_DASH1: begin
                if (c == "-") begin
                    lx_mode = M_COMMENT;
                    lx_dashes = 0;
                end else lex_fail(c, E_COMMENT);
            end
            M_COMMENT: begin
                if (c == 0) lex_fail(c, E_COMMENT);
                else if (lx_dashes >= 2) begin
                    lx_dashes = 0;
                    if (c == ">") lx_mode = M_AFTER_GT;
                    else lex_fail(c, E_COMMENT);
                end else lx_dashes = (c == "-") ? lx_dashes + 1 : 0;
            end
            M_ATTR_SKIP: begin
                if (ws(c)) ;
                else if (alpha(c)) begin
                    lx_mode = M_ATTR_NAME;
                    emit(OK_DATA, TK_ATTR, c, 4'd0);
                end else lex_dispatch(c);
            end
            M_ATTR_NAME: begin
                if (c == "=") begin
                    lx_mode = M_VAL_PRE;
                    emit(OK_DONE, TK_ATTR, 8'h00, 4'd0);
                end else if (ws(c)) begin
                    lx_mode = M_POST_NAME;
                    emit(OK_DONE, TK_ATTR, 8'h00, 4'd0);
                end else if (wordc(c)) emit(OK_DATA, TK_ATTR, c, 4'd0);
                else lex_fail(c, c == 0 ? E_ATTR_END : E_ATTR_CHAR);
            end
            M_POST_NAME: if (!ws(c)) lex_dispatch(c);
            M_VAL_PRE: begin
                if (ws(c)) ;
                else if (c == 8'h22) begin
                    lx_apos = 0;
                    lx_mode = M_VAL_BODY;
                end else if (c == 8'h27) begin
                    lx_apos = 1;
                    lx_mode = M_VAL_BODY;
                end else lex_fail(c, E_NO_QUOTE);
            end
            M_VAL_BODY: begin
                q = lx_apos ? 8'h27 : 8'h22;
                if (c == q) begin
                    lx_mode = M_START;
                    emit(OK_DONE, TK_VAL, 8'h00, 4'd0);
                end else if (c == 8'h22 || c == 8'h27) lex_fail(c, E_WRONG_QUOTE);
                else if (c == "&") lex_open_entity(1'b1);
                else if (c == 0) lex_fail(c, E_VAL_END);
                else emit(OK_DATA, TK_VAL, c, 4'd0);
            end
            M_ENTITY: lex_entity(c);
            M_SLASH: begin
                if (c == ">") begin
                    lx_mode = M_AFTER_GT;
                    emit(OK_DONE, TK_SELF, 8'h00, 4'd0);
                end else lex_fail(c, E_SLASH);
            end
            M_QM: begin
                if (c == ">") begin
                    lx_mode = M_AFTER_GT;
                    emit(OK_DONE, TK_PRO_END, 8'h00, 4'd0);
                end else lex_fail(c, E_QM);
            end
            M_ERR: if (c == 0) lx_mode = M_START;
            default: lex_dispatch(c);
        endcase
    endtask

    // drive one byte; holds valid until the transaction completes
    task automatic send_byte(input logic [7:0] c);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lex_byte(c);
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    function automatic string rand_word(input int n);
        string s;
        byte   c;
        s = "";
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: c = 8'(8'h41 + $urandom_range(0, 25));
                1: c = 8'(8'h61 + $urandom_range(0, 25));
                2: c = (k == 0) ? "_" : 8'(8'h30 + $urandom_range(0, 9));
                default: c = "x";
            endcase
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string rand_content(input int n);
        string s;
        byte   c;
        s = "";
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: s = {s, "&amp;"};
                1: s = {s, "&lt;"};
                2: s = {s, "&quot;"};
                3: s = {s, "&apos;"};
                4: s = {s, "&gt;"};
                default: begin
                    c = 8'($urandom_range(1, 255));
                    // keep markup and quote bytes out of plain content
                    if (c == "<" || c == "&" || c == 8'h22 || c == 8'h27) c = "a";
                    s = {s, string'(c)};
                end
            endcase
        end
        return s;
    endfunction

    function automatic string rand_ws();
        case ($urandom_range(0, 4))
            0: return "\n";
            1: return "\t";
            2: return "\r";
            default: return " ";
        endcase
    endfunction

    task automatic send_document();
        string a;
        int    n;
        if ($urandom_range(0, 2) == 0)
            send_str({"<?", rand_word($urandom_range(1, 4)), " v=\"1\"?>"});
        n = $urandom_range(1, 4);
        for (int e = 0; e < n; e++) begin
            a = rand_word($urandom_range(1, 5));
            send_str({"<", a});
            repeat ($urandom_range(0, 2)) begin
                send_str({rand_ws(), rand_word($urandom_range(1, 4))});
                if ($urandom_range(0, 1)) send_str(rand_ws());
                send_str("=");
                if ($urandom_range(0, 1)) send_str({"'", rand_content($urandom_range(0, 5)), "'"});
                else send_str({"\"", rand_content($urandom_range(0, 5)), "\""});
            end
            if ($urandom_range(0, 3) == 0) send_str("/>");
            else begin
                send_str({">", rand_ws(), rand_content($urandom_range(0, 8))});
                if ($urandom_range(0, 3) == 0) send_str("<!-- c-x - -->");
                send_str({"</", a, ">"});
            end
        end
        send_byte(8'h00);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: send_byte(8'($urandom_range(0, 255)));
                1: send_str("<a");
                2: send_str("=\"&");
                default: send_byte(8'($urandom_range(1, 255)));
            endcase
        end
        send_byte(8'h00);
    endtask

    task automatic wait_drain();
        while (token_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic test_well_formed();
        send_str("<?xml v='1'?><a b=\"&lt;&gt;&amp;&apos;&quot;\">  hi&amp;</a>");
        send_byte(8'h00);
        send_str("<r\nx = 'y'/><!-- -- -->z<b />");
        send_byte(8'h00);
    endtask

    task automatic test_errors();
        string cases[13];
        cases = '{"</a/x", "<?p?x", "<1", "abc", "<a#", "<!x", "<a b",
                  "<a b#", "<a b=x", "<a b='x\"", "<a b='x", "x&abcdef;",
                  "<a b='1' #"};
        foreach (cases[k]) begin
            send_str(cases[k]);
            send_str("junk>");
            send_byte(8'h00);
        end
        send_str("<!-- x");
        send_byte(8'h00);
        send_str("x&zz;");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 14) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_document();
            sent++;
        end
    endtask

    task automatic test_full_rate();
        idle_en = 0;
        repeat (3) send_document();
        i_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_valid && i_ready) begin
            if (token_q.size() == 0) begin
                $error("unexpected result kind %0d", o_out_kind);
                fail_cnt++;
            end else begin
                r = token_q.pop_front();
                if (o_out_kind !== r.out_kind) begin
                    $error("out_kind exp %0d got %0d", r.out_kind, o_out_kind);
                    fail_cnt++;
                end
                if (o_token_kind !== r.token_kind) begin
                    $error("token_kind exp %0d got %0d", r.token_kind, o_token_kind);
                    fail_cnt++;
                end
                if (o_data_char !== r.data_char) begin
                    $error("data_char exp %0h got %0h", r.data_char, o_data_char);
                    fail_cnt++;
                end
                if (o_error_code !== r.error_code) begin
                    $error("error_code exp %0d got %0d", r.error_code, o_error_code);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!idle_en) i_ready <= 1'b1;
        else if ($urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
        end else i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        idle_en = 1;
        lx_mode = M_START;
        lx_apos = 0;
        lx_ent_len = 0;
        lx_ent_val = 0;
        lx_dashes = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_char_code = 8'h00;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_well_formed();
        test_errors();
        test_random();
        test_full_rate();
        wait_drain();
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0 && token_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
